/* rtl/core/mbd_pkg.sv */
package mbd_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int LINE_DEPTH   = MAX_WIDTH / 2;

   localparam int CH_W    = 8;
   localparam int TEXEL_W = 4 * CH_W;
   localparam int PSUM_W  = CH_W + 1;
   localparam int SUM_W   = 4 * PSUM_W;

   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int HGT_W   = $clog2(HEIGHT_LIMIT + 1);
   localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
   localparam int EXT_W   = (CFG_W > WIDTH_W) ? CFG_W : WIDTH_W;
   localparam int EXTH_W  = (CFG_W > HGT_W) ? CFG_W : HGT_W;
   localparam int DIM_W   = (WIDTH_W > HGT_W) ? WIDTH_W : HGT_W;
   localparam int ADDR_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);

   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESERVE_BORDER = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_WRITE  = 2'd0;
   localparam kind_type KIND_READ   = 2'd1;
   localparam kind_type KIND_DIRECT = 2'd2;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   addr;
      logic [SUM_W-1:0]    data;
      logic                last;
      logic                err;
   } cmd_type;

endpackage

/* rtl/core/mipmap_box_downsample_border_unit.sv */
// 2x2 box filter mip level generator for rgba8 texels
//
// req_* carries source texels in raster order, one beat per texel; rsp_* carries
// the output mip level in raster order with frame_last on its final texel and
// size_error on every beat of a 1x1 source. csr_* writes in_width, in_height and
// preserve_border (index 0, 1, 2); csr_ready is always high, a write restarts
// the frame; the user must see that it is only issued while the block is idle, the block itself does not enforce this.
// throughput: one texel per cycle, sustained with rsp_stall low; the line store
// takes at most one write or one read per texel and so never limits the rate.
// a result beat passes the command queue, stage s1 and the output register
// after the texel that completes it is accepted, and then shows on rsp_valid.
// a four entry command queue sits between the classifier and the datapath;
// req_stall rises only when that queue is full, so a stalled rsp side holds its
// beat steady and backs up into req once the queue and the two stages behind it
// are taken, after at most six texels that produce output (line store writes
// hold a queue entry but no stage).
// reset (synchronous) clears counters, queue and output valid and loads
// in_width = in_height = 256, preserve_border = 0; the line store needs no clear.
module mipmap_box_downsample_border_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbd_pkg::CFG_W-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   input  logic [7:0]                    req_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic [7:0]                    rsp_out_alpha,
   output logic                          rsp_frame_last,
   output logic                          rsp_size_error
);

   logic                        q_full, q_not_empty, q_push, q_pop, req_fire;
   mbd_pkg::cmd_type            q_in, q_head;
   logic [mbd_pkg::TEXEL_W-1:0] rsp_texel;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign req_fire  = req_valid && !q_full;

   mbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_fire  (req_fire),
      .texel     ({req_alpha, req_blue, req_green, req_red}),
      .push      (q_push),
      .cmd       (q_in)
   );

   mbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_texel (rsp_texel),
      .rsp_last  (rsp_frame_last),
      .rsp_err   (rsp_size_error)
   );

   assign rsp_out_red   = rsp_texel[7:0];
   assign rsp_out_green = rsp_texel[15:8];
   assign rsp_out_blue  = rsp_texel[23:16];
   assign rsp_out_alpha = rsp_texel[31:24];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("command queue underflow");

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_size_error) |-> (rsp_frame_last && rsp_out_red == 8'd0
         && rsp_out_green == 8'd0 && rsp_out_blue == 8'd0 && rsp_out_alpha == 8'd0))
      else $error("size error beat carries data");
`endif

endmodule

/* rtl/core/mbd_ram.sv */
module mbd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mbd_front.sv */
module mbd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_fire,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbd_pkg::CFG_W-1:0]        csr_data,
   input  logic                             req_fire,
   input  logic [mbd_pkg::TEXEL_W-1:0]      texel,
   output logic                             push,
   output mbd_pkg::cmd_type                 cmd
);

   logic [mbd_pkg::CFG_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic                        border_en_ff, border_en_in;
   logic [mbd_pkg::COL_W-1:0]   col_ff, col_in;
   logic [mbd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [mbd_pkg::TEXEL_W-1:0] held_ff, held_in, border_ff, border_in;

   logic [mbd_pkg::WIDTH_W-1:0] eff_w, ow;
   logic [mbd_pkg::HGT_W-1:0]   eff_h, oh;
   logic [mbd_pkg::DIM_W-1:0]   n_pairs, pos_half;
   logic [mbd_pkg::COL_W-1:0]   ox;
   logic [mbd_pkg::ROW_W-1:0]   oy;
   logic                        one_by_one, line_1d, row_mode, pos_odd;
   logic                        in_range, in_line, ring;
   logic [mbd_pkg::SUM_W-1:0]   pair_sum;
   logic [mbd_pkg::TEXEL_W-1:0] avg_1d;

   // effective sizes
   always_comb begin
      if (width_ff == '0) begin
         eff_w = mbd_pkg::WIDTH_W'(1);
      end else if (mbd_pkg::EXT_W'(width_ff) > mbd_pkg::EXT_W'(mbd_pkg::MAX_WIDTH)) begin
         eff_w = mbd_pkg::WIDTH_W'(mbd_pkg::MAX_WIDTH);
      end else begin
         eff_w = mbd_pkg::WIDTH_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = mbd_pkg::HGT_W'(1);
      end else if (mbd_pkg::EXTH_W'(height_ff) > mbd_pkg::EXTH_W'(mbd_pkg::HEIGHT_LIMIT)) begin
         eff_h = mbd_pkg::HGT_W'(mbd_pkg::HEIGHT_LIMIT);
      end else begin
         eff_h = mbd_pkg::HGT_W'(height_ff);
      end
   end

   assign ow         = eff_w >> 1;
   assign oh         = eff_h >> 1;
   assign one_by_one = (eff_w == mbd_pkg::WIDTH_W'(1)) && (eff_h == mbd_pkg::HGT_W'(1));
   assign row_mode   = (eff_h == mbd_pkg::HGT_W'(1));
   assign line_1d    = (eff_w == mbd_pkg::WIDTH_W'(1)) || row_mode;

   // 1d position along the long axis
   always_comb begin
      if (row_mode) begin
         n_pairs  = mbd_pkg::DIM_W'(eff_w) >> 1;
         pos_half = mbd_pkg::DIM_W'(col_ff) >> 1;
         pos_odd  = col_ff[0];
      end else begin
         n_pairs  = mbd_pkg::DIM_W'(eff_h) >> 1;
         pos_half = mbd_pkg::DIM_W'(row_ff) >> 1;
         pos_odd  = row_ff[0];
      end
   end

   assign ox       = col_ff >> 1;
   assign oy       = row_ff >> 1;
   assign in_range = (mbd_pkg::WIDTH_W'(col_ff) + mbd_pkg::WIDTH_W'(0) < ow + ow)
                  && (mbd_pkg::HGT_W'(row_ff) < oh + oh);
   assign in_line  = mbd_pkg::WIDTH_W'(ox) < mbd_pkg::WIDTH_W'(mbd_pkg::LINE_DEPTH);
   assign ring     = (ox == '0) || (oy == '0)
                  || (mbd_pkg::WIDTH_W'(ox) == ow - mbd_pkg::WIDTH_W'(1))
                  || (mbd_pkg::HGT_W'(oy) == oh - mbd_pkg::HGT_W'(1));

   // per channel pair sums and 1d means
   always_comb begin
      logic [mbd_pkg::PSUM_W-1:0] s;
      for (int k = 0; k < 4; k++) begin
         s = mbd_pkg::PSUM_W'(held_ff[k*mbd_pkg::CH_W +: mbd_pkg::CH_W])
           + mbd_pkg::PSUM_W'(texel[k*mbd_pkg::CH_W +: mbd_pkg::CH_W]);
         pair_sum[k*mbd_pkg::PSUM_W +: mbd_pkg::PSUM_W] = s;
         avg_1d[k*mbd_pkg::CH_W +: mbd_pkg::CH_W]       = s[mbd_pkg::PSUM_W-1:1];
      end
   end

   // classify
   always_comb begin
      push      = 1'b0;
      cmd.kind  = mbd_pkg::KIND_DIRECT;
      cmd.addr  = ox[mbd_pkg::ADDR_W-1:0];
      cmd.data  = pair_sum;
      cmd.last  = 1'b0;
      cmd.err   = 1'b0;
      held_in   = held_ff;
      border_in = border_ff;
      if (req_fire) begin
         if (one_by_one) begin
            push     = 1'b1;
            cmd.data = '0;
            cmd.last = 1'b1;
            cmd.err  = 1'b1;
         end else begin
            if (col_ff == '0 && row_ff == '0) begin
               border_in = texel;
            end
            if (line_1d) begin
               if (!pos_odd) begin
                  held_in = texel;
               end else if (pos_half < n_pairs) begin
                  push     = 1'b1;
                  cmd.data = mbd_pkg::SUM_W'(border_en_ff ? border_ff : avg_1d);
                  cmd.last = (pos_half == n_pairs - mbd_pkg::DIM_W'(1));
               end
            end else if (in_range) begin
               if (!col_ff[0]) begin
                  held_in = texel;
               end else if (in_line) begin
                  push     = 1'b1;
                  cmd.last = (mbd_pkg::WIDTH_W'(ox) == ow - mbd_pkg::WIDTH_W'(1))
                          && (mbd_pkg::HGT_W'(oy) == oh - mbd_pkg::HGT_W'(1));
                  if (!row_ff[0]) begin
                     cmd.kind = mbd_pkg::KIND_WRITE;
                  end else if (border_en_ff && ring) begin
                     cmd.data = mbd_pkg::SUM_W'(border_ff);
                  end else begin
                     cmd.kind = mbd_pkg::KIND_READ;
                  end
               end
            end
         end
      end
   end

   // counters and config
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      border_en_in = border_en_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (csr_fire) begin
         unique case (csr_index)
            mbd_pkg::REG_IN_WIDTH: begin
               width_in = csr_data;
               col_in   = '0;
               row_in   = '0;
            end
            mbd_pkg::REG_IN_HEIGHT: begin
               height_in = csr_data;
               col_in    = '0;
               row_in    = '0;
            end
            mbd_pkg::REG_PRESERVE_BORDER: begin
               border_en_in = csr_data[0];
               col_in       = '0;
               row_in       = '0;
            end
            default: begin
            end
         endcase
      end else if (req_fire && !one_by_one) begin
         if (mbd_pkg::WIDTH_W'(col_ff) + mbd_pkg::WIDTH_W'(1) >= eff_w) begin
            col_in = '0;
            if (mbd_pkg::HGT_W'(row_ff) + mbd_pkg::HGT_W'(1) >= eff_h) begin
               row_in = '0;
            end else begin
               row_in = row_ff + mbd_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + mbd_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= mbd_pkg::WIDTH_RESET;
         height_ff    <= mbd_pkg::HEIGHT_RESET;
         border_en_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         border_ff    <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         border_en_ff <= border_en_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         border_ff    <= border_in;
      end
   end

endmodule

/* rtl/core/mbd_queue.sv */
module mbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output mbd_pkg::cmd_type head
);

   mbd_pkg::cmd_type            ent_ff [mbd_pkg::QUEUE_DEPTH];
   logic [mbd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mbd_pkg::QPTR_W:0]    count_ff, count_in;

   assign full      = (count_ff == (mbd_pkg::QPTR_W+1)'(mbd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mbd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mbd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (mbd_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (mbd_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/mbd_back.sv */
module mbd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  mbd_pkg::cmd_type            cmd,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mbd_pkg::TEXEL_W-1:0] rsp_texel,
   output logic                        rsp_last,
   output logic                        rsp_err
);

   logic                        s1_valid_ff, s1_valid_in;
   mbd_pkg::kind_type           s1_kind_ff;
   logic [mbd_pkg::SUM_W-1:0]   s1_data_ff;
   logic                        s1_last_ff, s1_err_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [mbd_pkg::TEXEL_W-1:0] out_texel_ff, result;
   logic                        out_last_ff, out_err_ff;
   logic                        out_ready, s1_ready, s1_load, wr_en, rd_en;
   logic [mbd_pkg::SUM_W-1:0]   up_sum;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop       = cmd_valid && s1_ready;
   assign wr_en     = pop && (cmd.kind == mbd_pkg::KIND_WRITE);
   assign rd_en     = pop && (cmd.kind == mbd_pkg::KIND_READ);
   assign s1_load   = pop && (cmd.kind != mbd_pkg::KIND_WRITE);

   mbd_ram #(
      .WIDTH (mbd_pkg::SUM_W),
      .DEPTH (mbd_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd.addr),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (cmd.addr),
      .rd_data (up_sum)
   );

   always_comb begin
      logic [mbd_pkg::PSUM_W:0] total;
      result = s1_data_ff[mbd_pkg::TEXEL_W-1:0];
      unique case (s1_kind_ff)
         mbd_pkg::KIND_READ: begin
            for (int k = 0; k < 4; k++) begin
               total = (mbd_pkg::PSUM_W+1)'(up_sum[k*mbd_pkg::PSUM_W +: mbd_pkg::PSUM_W])
                     + (mbd_pkg::PSUM_W+1)'(s1_data_ff[k*mbd_pkg::PSUM_W +: mbd_pkg::PSUM_W]);
               result[k*mbd_pkg::CH_W +: mbd_pkg::CH_W] = total[mbd_pkg::PSUM_W:2];
            end
         end
         default: begin
            result = s1_data_ff[mbd_pkg::TEXEL_W-1:0];
         end
      endcase
   end

   assign s1_valid_in  = s1_ready ? s1_load : s1_valid_ff;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_load) begin
         s1_kind_ff <= cmd.kind;
         s1_data_ff <= cmd.data;
         s1_last_ff <= cmd.last;
         s1_err_ff  <= cmd.err;
      end
      if (out_ready && s1_valid_ff) begin
         out_texel_ff <= result;
         out_last_ff  <= s1_last_ff;
         out_err_ff   <= s1_err_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_texel = out_texel_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_err   = out_err_ff;

endmodule

/* bench/tb_mipmap_box_downsample_border_unit.sv */
`timescale 1ns / 1ps

module tb_mipmap_box_downsample_border_unit;

   localparam int CLK_PERIOD     = 12;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int RANDOM_TEXELS  = 350;
   localparam int BURST_TEXELS   = 200;
   localparam int SHORT_RUN      = 64;

   // index with no register behind it
   localparam logic [mbd_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef logic [3:0][7:0] texel_type;
   typedef logic [3:0][8:0] pair_sum_type;

   typedef struct packed {
      texel_type color;
      logic      last;
      logic      err;
   } mip_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [mbd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mbd_pkg::CFG_W-1:0]     csr_data;
   logic                          req_valid;
   logic                          req_stall;
   logic [7:0]                    req_red;
   logic [7:0]                    req_green;
   logic [7:0]                    req_blue;
   logic [7:0]                    req_alpha;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [7:0]                    rsp_out_red;
   logic [7:0]                    rsp_out_green;
   logic [7:0]                    rsp_out_blue;
   logic [7:0]                    rsp_out_alpha;
   logic                          rsp_frame_last;
   logic                          rsp_size_error;

   // predictor state
   logic [mbd_pkg::CFG_W-1:0] model_width;
   logic [mbd_pkg::CFG_W-1:0] model_height;
   logic                      model_border;
   pair_sum_type              pair_line [0:mbd_pkg::LINE_DEPTH-1];
   texel_type                 held_texel;
   texel_type                 border_texel;
   int                        col_pos;
   int                        row_pos;

   mip_beat_type pending_beats [$];

   bit quiet;
   int mismatches;
   int texels_sent;
   int beats_checked;
   int frame_ends;
   int size_errors;
   int csr_writes;

   mipmap_box_downsample_border_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_frame_last (rsp_frame_last),
      .rsp_size_error (rsp_size_error)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !quiet && ($urandom_range(99) < 9);
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout with %0d results outstanding", pending_beats.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int clamp_size(input logic [mbd_pkg::CFG_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return int'(v);
   endfunction

   function automatic void reset_model();
      model_width  = mbd_pkg::WIDTH_RESET;
      model_height = mbd_pkg::HEIGHT_RESET;
      model_border = 1'b0;
      held_texel   = '0;
      border_texel = '0;
      col_pos      = 0;
      row_pos      = 0;
      for (int i = 0; i < mbd_pkg::LINE_DEPTH; i++) pair_line[i] = '0;
   endfunction

   function automatic void apply_csr_write(input logic [mbd_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [mbd_pkg::CFG_W-1:0] data);
      case (idx)
         mbd_pkg::REG_IN_WIDTH:        model_width  = data;
         mbd_pkg::REG_IN_HEIGHT:       model_height = data;
         mbd_pkg::REG_PRESERVE_BORDER: model_border = data[0];
         default:                      return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic void predict_mip_texel(input texel_type t, output bit produced,
                                             output mip_beat_type beat);
      int           w;
      int           h;
      int           p;
      int           n;
      int           ow;
      int           oh;
      int           ox;
      int           oy;
      int           k;
      bit           ring;
      pair_sum_type sums;
      pair_sum_type above;
      texel_type    color;
      w = clamp_size(model_width, mbd_pkg::MAX_WIDTH);
      h = clamp_size(model_height, mbd_pkg::HEIGHT_LIMIT);
      produced = 1'b0;
      beat = '0;
      // one by one source: error beat, counters hold
      if (w == 1 && h == 1) begin
         produced = 1'b1;
         beat.last = 1'b1;
         beat.err = 1'b1;
         return;
      end
      if (col_pos == 0 && row_pos == 0) border_texel = t;
      if (w == 1 || h == 1) begin
         p = (h == 1) ? col_pos : row_pos;
         n = ((h == 1) ? w : h) / 2;
         if (p % 2 == 0) begin
            held_texel = t;
         end else if (p / 2 < n) begin
            for (k = 0; k < 4; k++) color[k] = 8'((9'(held_texel[k]) + 9'(t[k])) >> 1);
            beat.color = model_border ? border_texel : color;
            beat.last = (p / 2 == n - 1);
            produced = 1'b1;
         end
      end else begin
         ow = w / 2;
         oh = h / 2;
         if (col_pos < 2 * ow && row_pos < 2 * oh) begin
            if (col_pos % 2 == 0) begin
               held_texel = t;
            end else begin
               ox = col_pos / 2;
               oy = row_pos / 2;
               for (k = 0; k < 4; k++) sums[k] = 9'(held_texel[k]) + 9'(t[k]);
               if (row_pos % 2 == 0) begin
                  pair_line[ox] = sums;
               end else begin
                  above = pair_line[ox];
                  for (k = 0; k < 4; k++) color[k] = 8'((10'(above[k]) + 10'(sums[k])) >> 2);
                  ring = ox == 0 || oy == 0 || ox == ow - 1 || oy == oh - 1;
                  beat.color = (model_border && ring) ? border_texel : color;
                  beat.last = ox == ow - 1 && oy == oh - 1;
                  produced = 1'b1;
               end
            end
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic logic [7:0] random_channel();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   function automatic texel_type random_texel();
      texel_type t;
      for (int k = 0; k < 4; k++) t[k] = random_channel();
      return t;
   endfunction

   function automatic texel_type make_texel(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a);
      return {a, b, g, r};
   endfunction

   function automatic logic [mbd_pkg::CFG_W-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 15) return mbd_pkg::CFG_W'(1);
      if (r < 25) return mbd_pkg::CFG_W'(2);
      if (r < 88) return mbd_pkg::CFG_W'($urandom_range(12, 3));
      return mbd_pkg::CFG_W'($urandom_range(40, 13));
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at result %0d: %s", beats_checked, what);
   endtask

   always @(posedge clock) begin : check_results
      mip_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = pending_beats.pop_front();
            if (rsp_out_red !== want.color[0])
               report_mismatch($sformatf("out_red %0d, expected %0d",
                                         rsp_out_red, want.color[0]));
            if (rsp_out_green !== want.color[1])
               report_mismatch($sformatf("out_green %0d, expected %0d",
                                         rsp_out_green, want.color[1]));
            if (rsp_out_blue !== want.color[2])
               report_mismatch($sformatf("out_blue %0d, expected %0d",
                                         rsp_out_blue, want.color[2]));
            if (rsp_out_alpha !== want.color[3])
               report_mismatch($sformatf("out_alpha %0d, expected %0d",
                                         rsp_out_alpha, want.color[3]));
            if (rsp_frame_last !== want.last)
               report_mismatch($sformatf("frame_last %b, expected %b",
                                         rsp_frame_last, want.last));
            if (rsp_size_error !== want.err)
               report_mismatch($sformatf("size_error %b, expected %b",
                                         rsp_size_error, want.err));
            frame_ends += want.last;
            size_errors += want.err;
         end
         beats_checked++;
      end
   end

   task automatic send_texel(input texel_type t);
      bit           produced;
      mip_beat_type beat;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= t[0];
      req_green <= t[1];
      req_blue  <= t[2];
      req_alpha <= t[3];
      do @(posedge clock); while (req_stall);
      predict_mip_texel(t, produced, beat);
      if (produced) pending_beats.push_back(beat);
      texels_sent++;
   endtask

   task automatic csr_write(input logic [mbd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mbd_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr_write(idx, data);
      csr_writes++;
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   // texels that produce nothing may still be in flight
   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_size(input logic [mbd_pkg::CFG_W-1:0] w,
                                 input logic [mbd_pkg::CFG_W-1:0] h,
                                 input logic border);
      wait_idle();
      csr_write(mbd_pkg::REG_IN_WIDTH, w);
      csr_write(mbd_pkg::REG_IN_HEIGHT, h);
      csr_write(mbd_pkg::REG_PRESERVE_BORDER,
                {(mbd_pkg::CFG_W-1)'($urandom_range(4095)), border});
      csr_done();
   endtask

   task automatic run_random_phases(input int budget);
      int                        sent;
      int                        area;
      int                        count;
      logic [mbd_pkg::CFG_W-1:0] w;
      logic [mbd_pkg::CFG_W-1:0] h;
      sent = 0;
      while (sent < budget) begin
         wait_idle();
         w = pick_size();
         h = pick_size();
         if (w > 12 && h > 4) h = mbd_pkg::CFG_W'($urandom_range(4, 2));
         if ($urandom_range(99) < 15) csr_write(REG_SPARE, mbd_pkg::CFG_W'($urandom_range(8191)));
         if ($urandom_range(99) < 85) csr_write(mbd_pkg::REG_IN_WIDTH, w);
         if ($urandom_range(99) < 85) csr_write(mbd_pkg::REG_IN_HEIGHT, h);
         if ($urandom_range(99) < 60)
            csr_write(mbd_pkg::REG_PRESERVE_BORDER, mbd_pkg::CFG_W'($urandom_range(8191)));
         csr_done();
         area = clamp_size(model_width, mbd_pkg::MAX_WIDTH)
              * clamp_size(model_height, mbd_pkg::HEIGHT_LIMIT);
         repeat ($urandom_range(3, 1)) begin
            count = area;
            // cut frames short now and then; the next size write restarts
            if ($urandom_range(9) == 0) count = $urandom_range(area, 1);
            repeat (count) send_texel(random_texel());
            sent += count;
         end
      end
   endtask

   task automatic test_reset_size();
      // 256 x 256 after reset: one full row then the first pair of the next
      repeat (258) send_texel(random_texel());
   endtask

   task automatic test_box_2d();
      configure_size(4, 4, 1'b0);
      repeat (2) begin
         send_texel(make_texel(255, 255, 255, 255));
         send_texel(make_texel(255, 255, 255, 255));
         send_texel(make_texel(0, 0, 0, 0));
         send_texel(make_texel(0, 0, 0, 0));
      end
      send_texel(make_texel(0, 255, 1, 254));
      send_texel(make_texel(255, 0, 254, 1));
      send_texel(make_texel(1, 2, 3, 4));
      send_texel(make_texel(200, 100, 50, 25));
      send_texel(make_texel(255, 0, 255, 0));
      send_texel(make_texel(255, 1, 254, 3));
      send_texel(make_texel(7, 9, 11, 13));
      send_texel(make_texel(128, 127, 129, 126));
   endtask

   task automatic test_line_1d();
      // odd width with border fill: last texel dropped
      configure_size(5, 1, 1'b1);
      send_texel(make_texel(17, 34, 51, 68));
      send_texel(make_texel(255, 255, 255, 255));
      send_texel(make_texel(0, 0, 0, 0));
      send_texel(make_texel(255, 0, 255, 0));
      send_texel(make_texel(99, 98, 97, 96));
      // zero width reads as one: vertical pairs, odd height
      configure_size(0, 3, 1'b0);
      send_texel(make_texel(255, 255, 0, 1));
      send_texel(make_texel(255, 0, 255, 254));
      send_texel(make_texel(42, 42, 42, 42));
   endtask

   task automatic test_single_texel();
      configure_size(1, 0, 1'b1);
      send_texel(make_texel(255, 255, 255, 255));
      send_texel(make_texel(1, 2, 3, 4));
   endtask

   task automatic test_size_limits();
      // width past the maximum saturates: short run along one row
      configure_size(4100, 1, 1'b1);
      repeat (SHORT_RUN) send_texel(random_texel());
      // height past the limit saturates: short run down one column
      configure_size(0, 8191, 1'b0);
      repeat (SHORT_RUN) send_texel(random_texel());
   endtask

   task automatic test_drain_pause();
      configure_size(6, 4, 1'b0);
      for (int row = 0; row < 4; row++) begin
         repeat (6) send_texel(random_texel());
         if (row == 1) begin
            // write to the spare index must not restart the frame
            wait_idle();
            csr_write(REG_SPARE, mbd_pkg::CFG_W'($urandom_range(8191)));
            csr_done();
         end else begin
            wait_results();
         end
      end
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      run_random_phases(BURST_TEXELS);
      wait_idle();
      quiet = 1'b0;
   endtask

   task automatic test_random_frames();
      run_random_phases(RANDOM_TEXELS);
   endtask

   initial begin
      quiet       = 1'b0;
      mismatches  = 0;
      texels_sent = 0;
      csr_writes  = 0;
      reset     <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= mbd_pkg::REG_IN_WIDTH;
      csr_data  <= '0;
      req_valid <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      req_alpha <= '0;
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_box_2d();
      test_line_1d();
      test_single_texel();
      test_size_limits();
      test_drain_pause();
      test_back_to_back();
      test_random_frames();

      wait_idle();
      $display("%0d texels in, %0d beats checked, %0d frame ends, %0d size errors",
               texels_sent, beats_checked, frame_ends, size_errors);
      $display("%0d register writes over 2d, 1d, 1x1, zero and saturated sizes, %0d mismatches",
               csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
